>>> rtl/kst_pkg.sv
// shared constants, codes and helpers of the kinematic state tracker
package kst_pkg;

  // storage
  localparam int CHANNELS_DEFAULT = 16;

  // field widths
  localparam int OP_W     = 2;
  localparam int CH_W     = 4;
  localparam int VAL_W    = 32;
  localparam int USER_W   = OP_W + CH_W;
  localparam int OUT_W    = 3 * VAL_W;

  // one history row: {last velocity, oldest, previous, newest position}
  localparam int ROW_W    = 4 * VAL_W;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE   = 1'd1;
  localparam logic [VAL_W-1:0] SAMPLE_PERIOD_RESET = 32'd4294967;
  localparam logic [VAL_W-1:0] SAMPLE_RATE_RESET   = 32'd4096000;

  // sample kinds
  localparam logic [OP_W-1:0] OP_POSITION = 2'd0;
  localparam logic [OP_W-1:0] OP_VELOCITY = 2'd1;
  localparam logic [OP_W-1:0] OP_ACCEL    = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

  // scaling datapath
  localparam int DIFF_W   = 35;             // signed second difference
  localparam int FACT_W   = 64;             // rate squared or period squared
  localparam int ACC_W    = DIFF_W + FACT_W;
  localparam int CLAMP_B  = 40;             // magnitude clamp is 2^40
  localparam int SRES_W   = CLAMP_B + 2;    // signed clamped scale result
  localparam int SUM_W    = 44;             // room for two results plus a position

  function automatic logic [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [VAL_W-1:0] res;
    if (v > $signed(SUM_W'(32'h7fff_ffff))) begin
      res = 32'h7fff_ffff;
    end else if (v < -$signed(SUM_W'(33'h0_8000_0000))) begin
      res = 32'h8000_0000;
    end else begin
      res = v[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/kst_ram.sv
// generic single-write, single-read ram with registered read data
module kst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/kinematic_state_tracker_core.sv
// kinematic state tracker: per-channel position, velocity and acceleration estimator
//
// Each request carries a sample kind (position, velocity or acceleration), a
// channel and a signed Q16.16 value, and gives one result with the channel and
// the three estimates, all Q16.16 and saturated to 32 bits. Position samples
// give velocity and acceleration by backward differences times the rate
// register (Q20.12 hertz); velocity samples integrate position by Euler;
// acceleration samples integrate velocity by Euler and position by Verlet
// with the period register (Q0.32 seconds). The first sample of a channel
// returns the raw value with zeros and seeds that channel's history. Kind 3
// and channels at or above CHANNELS are dropped without a result. All
// products go through one 32x32 multiplier: each scaling takes four partial
// products, and a square of the rate or period one more multiply. Position and
// velocity samples take two scalings and a square, acceleration samples three
// scalings and a square, and a channel's first sample none. s_axis_tready is
// low while a request is in work. A finished result sits in the output
// register, and the next request is taken while it waits. The history lives
// in a ram of CHANNELS rows; first-sample flags are flops that reset sets,
// so no clearing pass is needed.
module kinematic_state_tracker_core
  import kst_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // request side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [VAL_W-1:0]       s_axis_tdata,   // sample_value
  input  logic [USER_W-1:0]      s_axis_tuser,   // op[1:0], channel[5:2]
  // result side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_W-1:0]       m_axis_tdata,   // position, velocity, acceleration
  output logic [CH_W-1:0]        m_axis_tuser,   // out_channel
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]       cfg_data
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHX_W  = 8 + CH_W;  // channel widened past any address width

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIRST, ST_SET, ST_M0, ST_M1, ST_M2, ST_M3, ST_MADD,
    ST_FIN, ST_COMB, ST_SQ, ST_SQW, ST_STORE, ST_OUT
  } state_t;

  // which scaling of the request is running
  typedef enum logic [1:0] {SLOT_A, SLOT_B, SLOT_C} slot_t;

  typedef enum logic [1:0] {SH_12, SH_24, SH_32, SH_65} shift_t;

  state_t state;
  slot_t  slot;
  shift_t sh_r;

  // configuration registers
  logic [VAL_W-1:0] sample_period;
  logic [VAL_W-1:0] sample_rate;

  // first-sample flags, one per channel
  logic [CHANNELS-1:0] pending;

  // request being worked on
  logic [OP_W-1:0]         op_r;
  logic [CH_W-1:0]         ch_r;
  logic signed [VAL_W-1:0] x_r;

  // estimates under construction
  logic signed [VAL_W-1:0] pos_r;
  logic signed [VAL_W-1:0] vel_r;
  logic signed [VAL_W-1:0] acc_r;

  // shared scaling unit
  logic [FACT_W-1:0]        f2;       // rate or period squared
  logic [FACT_W-1:0]        f_r;
  logic [DIFF_W-1:0]        mag;
  logic                     neg_r;
  logic [ACC_W-1:0]         acc;
  logic [2*VAL_W-1:0]       prod;
  logic signed [SRES_W-1:0] sres;
  logic signed [SRES_W-1:0] sb_r;     // velocity term of the verlet step

  // history ram
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;

  logic signed [VAL_W-1:0] h0, h1, h2, lv;

  // request decode
  logic [OP_W-1:0]   in_op;
  logic [CH_W-1:0]   in_ch;
  logic [CHX_W-1:0]  in_chx;
  logic [CHX_W-1:0]  ch_rx;
  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] ch_addr;
  logic              in_range;
  logic              accept;
  logic              out_load;

  // combinational datapath
  logic signed [DIFF_W-1:0] d_sel;
  logic [FACT_W-1:0]        f_sel;
  shift_t                   sh_sel;
  logic [DIFF_W-1:0]        mag_sel;
  logic [VAL_W-1:0]         mul_a, mul_b;
  logic [ACC_W-1:0]         acc_add;
  logic [ACC_W-1:0]         q;
  logic                     clamp_hit;
  logic [CLAMP_B:0]         r_mag;
  logic signed [SRES_W-1:0] sres_sel;
  logic signed [SUM_W-1:0]  sum_a, sum_c;
  logic signed [VAL_W-1:0]  first_pos, first_vel, first_acc;

  assign in_op    = s_axis_tuser[OP_W-1:0];
  assign in_ch    = s_axis_tuser[USER_W-1:OP_W];
  assign in_chx   = {8'd0, in_ch};
  assign ch_rx    = {8'd0, ch_r};
  assign in_addr  = in_chx[ADDR_W-1:0];
  assign ch_addr  = ch_rx[ADDR_W-1:0];
  assign in_range = 32'(in_chx) < CHANNELS;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // hand over once the output register is free or being emptied
  assign out_load = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  // row layout: newest position low, last velocity high
  assign h0 = ram_rdata[VAL_W-1:0];
  assign h1 = ram_rdata[2*VAL_W-1:VAL_W];
  assign h2 = ram_rdata[3*VAL_W-1:2*VAL_W];
  assign lv = ram_rdata[4*VAL_W-1:3*VAL_W];

  // read follows the incoming channel while idle so the row is ready at once
  assign ram_raddr = (state == ST_IDLE) ? in_addr : ch_addr;
  assign ram_waddr = ch_addr;
  assign ram_we    = (state == ST_FIRST) || (state == ST_STORE);

  // first sample goes to its own quantity, the others are zero
  assign first_pos = (op_r == OP_POSITION) ? x_r : '0;
  assign first_vel = (op_r == OP_VELOCITY) ? x_r : '0;
  assign first_acc = (op_r == OP_ACCEL)    ? x_r : '0;

  always_comb begin
    if (state == ST_FIRST) begin
      ram_wdata = {first_vel, first_pos, first_pos, first_pos};
    end else begin
      ram_wdata = {vel_r, h1, h0, pos_r};
    end
  end

  // operand selection for the next scaling
  always_comb begin
    d_sel  = '0;
    f_sel  = '0;
    sh_sel = SH_32;
    case (slot)
      SLOT_A: begin
        if (op_r == OP_POSITION) begin
          d_sel  = {{3{x_r[VAL_W-1]}}, x_r} - {{3{h0[VAL_W-1]}}, h0};
          f_sel  = {32'd0, sample_rate};
          sh_sel = SH_12;
        end else begin
          d_sel  = {{3{x_r[VAL_W-1]}}, x_r};
          f_sel  = {32'd0, sample_period};
          sh_sel = SH_32;
        end
      end
      SLOT_B: begin
        d_sel  = {{3{vel_r[VAL_W-1]}}, vel_r};
        f_sel  = {32'd0, sample_period};
        sh_sel = SH_32;
      end
      SLOT_C: begin
        f_sel = f2;
        case (op_r)
          OP_POSITION: begin
            d_sel  = {{3{x_r[VAL_W-1]}}, x_r} - ({{3{h0[VAL_W-1]}}, h0} <<< 1)
                     + {{3{h1[VAL_W-1]}}, h1};
            sh_sel = SH_24;
          end
          OP_VELOCITY: begin
            d_sel  = {{3{h0[VAL_W-1]}}, h0} - ({{3{h1[VAL_W-1]}}, h1} <<< 1)
                     + {{3{h2[VAL_W-1]}}, h2};
            sh_sel = SH_24;
          end
          default: begin
            d_sel  = {{3{x_r[VAL_W-1]}}, x_r};
            sh_sel = SH_65;
          end
        endcase
      end
      default: begin
        d_sel = '0;
      end
    endcase
    mag_sel = d_sel[DIFF_W-1] ? DIFF_W'(-d_sel) : DIFF_W'(d_sel);
  end

  // shared multiplier operands: square, or one limb pair of the scaling
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        mul_a = (op_r == OP_ACCEL) ? sample_period : sample_rate;
        mul_b = mul_a;
      end
      ST_M0: begin
        mul_a = mag[VAL_W-1:0];
        mul_b = f_r[VAL_W-1:0];
      end
      ST_M1: begin
        mul_a = mag[VAL_W-1:0];
        mul_b = f_r[FACT_W-1:VAL_W];
      end
      ST_M2: begin
        mul_a = {{(2*VAL_W-DIFF_W){1'b0}}, mag[DIFF_W-1:VAL_W]};
        mul_b = f_r[VAL_W-1:0];
      end
      ST_M3: begin
        mul_a = {{(2*VAL_W-DIFF_W){1'b0}}, mag[DIFF_W-1:VAL_W]};
        mul_b = f_r[FACT_W-1:VAL_W];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // partial product from the previous cycle, placed at its weight
  always_comb begin
    case (state)
      ST_M1:        acc_add = {{(ACC_W-2*VAL_W){1'b0}}, prod};
      ST_M2, ST_M3: acc_add = {{(ACC_W-2*VAL_W){1'b0}}, prod} << VAL_W;
      ST_MADD:      acc_add = {{(ACC_W-2*VAL_W){1'b0}}, prod} << (2 * VAL_W);
      default:      acc_add = '0;
    endcase
  end

  // truncating shift, clamp to 2^40, sign back on
  always_comb begin
    case (sh_r)
      SH_12:   q = acc >> 12;
      SH_24:   q = acc >> 24;
      SH_32:   q = acc >> 32;
      SH_65:   q = acc >> 65;
      default: q = acc;
    endcase
    clamp_hit = (|q[ACC_W-1:CLAMP_B+1]) || (q[CLAMP_B] && (|q[CLAMP_B-1:0]));
    r_mag     = clamp_hit ? {1'b1, {CLAMP_B{1'b0}}} : q[CLAMP_B:0];
    sres_sel  = neg_r ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
  end

  // sums ahead of the final saturation
  always_comb begin
    if (op_r == OP_ACCEL) begin
      sum_a = {{(SUM_W-VAL_W){lv[VAL_W-1]}}, lv};
    end else begin
      sum_a = {{(SUM_W-VAL_W){h0[VAL_W-1]}}, h0};
    end
    if (op_r != OP_POSITION) begin
      sum_a = sum_a + {{(SUM_W-SRES_W){sres[SRES_W-1]}}, sres};
    end else begin
      sum_a = {{(SUM_W-SRES_W){sres[SRES_W-1]}}, sres};
    end
    if (op_r == OP_ACCEL) begin
      sum_c = {{(SUM_W-VAL_W){h0[VAL_W-1]}}, h0}
              + {{(SUM_W-SRES_W){sb_r[SRES_W-1]}}, sb_r}
              + {{(SUM_W-SRES_W){sres[SRES_W-1]}}, sres};
    end else begin
      sum_c = {{(SUM_W-SRES_W){sres[SRES_W-1]}}, sres};
    end
  end

  kst_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot          <= SLOT_A;
      pending       <= '1;
      sample_period <= SAMPLE_PERIOD_RESET;
      sample_rate   <= SAMPLE_RATE_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      prod <= {32'd0, mul_a} * {32'd0, mul_b};

      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLE_PERIOD: sample_period <= cfg_data;
          REG_SAMPLE_RATE:   sample_rate   <= cfg_data;
          default:           sample_rate   <= sample_rate;
        endcase
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept && (in_op != OP_NONE) && in_range) begin
            op_r  <= in_op;
            ch_r  <= in_ch;
            x_r   <= s_axis_tdata;
            // the sample's own quantity is passed through as is
            pos_r <= s_axis_tdata;
            vel_r <= s_axis_tdata;
            acc_r <= s_axis_tdata;
            slot  <= SLOT_A;
            state <= pending[in_addr] ? ST_FIRST : ST_SET;
          end
        end
        ST_FIRST: begin
          pos_r            <= first_pos;
          vel_r            <= first_vel;
          acc_r            <= first_acc;
          pending[ch_addr] <= 1'b0;
          state            <= ST_OUT;
        end
        ST_SET: begin
          neg_r <= d_sel[DIFF_W-1];
          mag   <= mag_sel;
          f_r   <= f_sel;
          sh_r  <= sh_sel;
          acc   <= '0;
          state <= ST_M0;
        end
        ST_M0: state <= ST_M1;
        ST_M1: begin
          acc   <= acc + acc_add;
          state <= ST_M2;
        end
        ST_M2: begin
          acc   <= acc + acc_add;
          state <= ST_M3;
        end
        ST_M3: begin
          acc   <= acc + acc_add;
          state <= ST_MADD;
        end
        ST_MADD: begin
          acc   <= acc + acc_add;
          state <= ST_FIN;
        end
        ST_FIN: begin
          sres  <= sres_sel;
          state <= ST_COMB;
        end
        ST_COMB: begin
          case (slot)
            SLOT_A: begin
              if (op_r == OP_VELOCITY) begin
                pos_r <= sat32(sum_a);
              end else begin
                vel_r <= sat32(sum_a);
              end
              if (op_r == OP_ACCEL) begin
                slot  <= SLOT_B;
                state <= ST_SET;
              end else begin
                state <= ST_SQ;
              end
            end
            SLOT_B: begin
              sb_r  <= sres;
              state <= ST_SQ;
            end
            default: begin
              if (op_r == OP_ACCEL) begin
                pos_r <= sat32(sum_c);
              end else begin
                acc_r <= sat32(sum_c);
              end
              state <= ST_STORE;
            end
          endcase
        end
        ST_SQ: state <= ST_SQW;
        ST_SQW: begin
          f2    <= prod;
          slot  <= SLOT_C;
          state <= ST_SET;
        end
        ST_STORE: state <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            m_axis_tdata <= {acc_r, vel_r, pos_r};
            m_axis_tuser <= ch_r;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
